>>> hdl/sbe_pkg.sv
// Shared opcodes, fault codes and widths of the stack bytecode executor.
package sbe_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [3:0] {
    OP_GOTO    = 4'd0,
    OP_ADD     = 4'd1,
    OP_AND     = 4'd2,
    OP_CONST   = 4'd3,
    OP_IFFALSE = 4'd4,
    OP_LOAD    = 4'd5,
    OP_LT      = 4'd6,
    OP_MUL     = 4'd7,
    OP_NOT     = 4'd8,
    OP_CALL    = 4'd9,
    OP_RET     = 4'd10,
    OP_STORE   = 4'd11,
    OP_SUB     = 4'd12,
    OP_PRINT   = 4'd13,
    OP_STOP    = 4'd14,
    OP_NOP     = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_UNDERFLOW = 2'd1,
    FAULT_OVERFLOW  = 2'd2,
    FAULT_CALL      = 2'd3
  } fault_e;

endpackage

>>> hdl/sbe_modc.sv
// Remainder of a 32-bit word by a constant: quotient estimate on capture, fix-up later.
module sbe_modc #(
  parameter int unsigned MODULUS = 16,
  parameter int unsigned REM_W   = (MODULUS > 1) ? $clog2(MODULUS) : 1
) (
  input  logic [sbe_pkg::WORD_W-1:0] x_i,     // word being captured
  output logic [sbe_pkg::WORD_W-1:0] quot_o,  // quotient estimate, to be registered
  input  logic [sbe_pkg::WORD_W-1:0] xq_i,    // captured word
  input  logic [sbe_pkg::WORD_W-1:0] quot_i,  // registered quotient estimate
  output logic [REM_W-1:0]           rem_o
);
  import sbe_pkg::*;

  localparam int unsigned LOG_M   = $clog2(MODULUS);
  localparam bit          IS_POW2 = ((MODULUS & (MODULUS - 1)) == 0);
  localparam int unsigned SHIFT   = (LOG_M > 0) ? LOG_M - 1 : 0;
  localparam longint unsigned RECIP =
    IS_POW2 ? 64'd0 : ((64'd1 << (WORD_W + SHIFT)) / MODULUS);

  generate
    if (IS_POW2) begin : g_pow2
      assign quot_o = '0;
      assign rem_o  = (MODULUS == 1) ? '0 : xq_i[REM_W-1:0];
    end else begin : g_recip
      logic [63:0]       prod;
      logic [63:0]       back;
      logic [WORD_W:0]   r0, r1, r2;

      // Estimate never exceeds the true quotient and trails it by at most two.
      assign prod   = 64'(xq_shift(x_i)) * RECIP;
      assign quot_o = prod[63:32];

      assign back = 64'(quot_i) * 64'(MODULUS);
      assign r0   = {1'b0, xq_i} - back[WORD_W:0];
      assign r1   = (r0 >= (WORD_W+1)'(2 * MODULUS)) ? r0 - (WORD_W+1)'(2 * MODULUS) : r0;
      assign r2   = (r1 >= (WORD_W+1)'(MODULUS)) ? r1 - (WORD_W+1)'(MODULUS) : r1;
      assign rem_o = r2[REM_W-1:0];
    end
  endgenerate

  function automatic logic [WORD_W-1:0] xq_shift(input logic [WORD_W-1:0] v);
    xq_shift = v >> SHIFT;
  endfunction

endmodule

>>> hdl/stack_bytecode_executor_unit.sv
// Top level of the stack bytecode executor: input register, execute logic, result register.
// An accepted instruction waits in the input register, executes once the result register
//   is free or being drained, and its result transaction is offered from that register.
// Throughput: one instruction per cycle unless results stall, set by the single execute
//   step that reads the cached top of stack and prefetched stack, frame and local reads.
// Reset: all control state clears at once; stack, frame and local memories are not cleared.
module stack_bytecode_executor_unit #(
  parameter int unsigned STACK_DEPTH      = 64,
  parameter int unsigned CALL_DEPTH       = 16,
  parameter int unsigned LOCALS_PER_FRAME = 16,
  parameter int unsigned METHOD_COUNT     = 256,
  parameter int unsigned METHOD_LENGTH    = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,       // entry_method
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,      // [31:0] operand
  input  logic [3:0]  s_axis_tuser,      // [3:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,      // [7:0] fetch_method, [17:8] fetch_pc,
                                         // [49:18] print_value, [50] halted,
                                         // [52:51] fault, [55:53] zero
  output logic [0:0]  m_axis_tuser       // [0] print_valid
);
  import sbe_pkg::*;

  localparam int unsigned TW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned FW   = $clog2(CALL_DEPTH);
  localparam int unsigned LW   = (LOCALS_PER_FRAME > 1) ? $clog2(LOCALS_PER_FRAME) : 1;
  localparam int unsigned BANK = CALL_DEPTH * LOCALS_PER_FRAME;
  localparam int unsigned BW   = $clog2(BANK);
  localparam int unsigned MW   = (METHOD_COUNT > 1) ? $clog2(METHOD_COUNT) : 1;
  localparam int unsigned PW   = $clog2(METHOD_LENGTH);

  // Handshakes.
  logic s_fire, exec_fire;
  logic iv_q, ov_q;

  // Input register.
  op_e               op_q;
  logic [WORD_W-1:0] arg_q;
  logic [WORD_W-1:0] pcq_q, mq_q;     // quotient estimates for the operand
  logic              lin_q;           // operand is a valid local index within the frame
  logic [WORD_W-1:0] lrd_q;           // prefetched local value

  // Architectural state.
  logic [TW-1:0]     top_q, top_d;
  logic [WORD_W-1:0] t0_q, t0_d, t1_q, t1_d;  // top two stack entries
  logic [WORD_W-1:0] srd_q;                   // third entry, from the stack memory
  logic [FW-1:0]     level_q, level_d;
  logic [MW+PW-1:0]  frd_q;                   // return frame of the current level
  logic [MW-1:0]     method_q, method_d;
  logic [PW-1:0]     pc_q, pc_d;
  logic              stopped_q, stopped_d;
  logic              fresh_q;

  // Configuration staging.
  logic              cfg_pend_q;
  logic [WORD_W-1:0] cfg_x_q, cfg_quot_q, cfg_quot;
  logic [MW-1:0]     cfg_rem;

  // Memories.
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [MW+PW-1:0]  frame_mem [CALL_DEPTH];
  logic [WORD_W-1:0] local_mem [BANK];

  // Memory write and read controls.
  logic              swe;
  logic [AW-1:0]     swaddr, sraddr;
  logic [WORD_W-1:0] swdata;
  logic [TW-1:0]     top_m3;
  logic              fwe;
  logic [FW-1:0]     fwaddr, fraddr;
  logic [MW+PW-1:0]  fwdata;
  logic              lwe;
  logic [BW-1:0]     lwaddr, lraddr;
  logic [WORD_W-1:0] lwdata;

  // Operand remainders.
  logic [WORD_W-1:0] pc_quot, m_quot;
  logic [PW-1:0]     jump_pc;
  logic [MW-1:0]     call_m;

  // Execute results.
  logic [PW-1:0]     pc_next;
  logic [1:0]        need, gives;
  fault_e            fault;
  logic              pv;
  logic [WORD_W-1:0] pval, bin_r, push_v;
  logic              arg_in_range;
  logic [WORD_W-1:0] mul_r;

  // Result register.
  logic [MW-1:0]     o_method_q;
  logic [PW-1:0]     o_pc_q;
  logic              o_pv_q, o_halt_q;
  logic [WORD_W-1:0] o_pval_q;
  fault_e            o_fault_q;
  logic [31:0]       o_method_ext, o_pc_ext;

  assign exec_fire     = iv_q && (!ov_q || m_axis_tready);
  assign s_axis_tready = !iv_q || exec_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Operand reductions: estimate on capture, fix-up during execute.
  sbe_modc #(.MODULUS(METHOD_LENGTH), .REM_W(PW)) u_mod_pc (
    .x_i(s_axis_tdata), .quot_o(pc_quot), .xq_i(arg_q), .quot_i(pcq_q), .rem_o(jump_pc)
  );

  sbe_modc #(.MODULUS(METHOD_COUNT), .REM_W(MW)) u_mod_call (
    .x_i(s_axis_tdata), .quot_o(m_quot), .xq_i(arg_q), .quot_i(mq_q), .rem_o(call_m)
  );

  sbe_modc #(.MODULUS(METHOD_COUNT), .REM_W(MW)) u_mod_cfg (
    .x_i(32'(cfg_wdata_i)), .quot_o(cfg_quot), .xq_i(cfg_x_q), .quot_i(cfg_quot_q),
    .rem_o(cfg_rem)
  );

  assign pc_next      = (pc_q == PW'(METHOD_LENGTH - 1)) ? '0 : pc_q + PW'(1);
  assign arg_in_range = arg_q < 32'(LOCALS_PER_FRAME);
  assign mul_r        = t1_q * t0_q;

  // Stack needs of each opcode.
  always_comb begin
    need  = 2'd0;
    gives = 2'd0;
    case (op_q)
      OP_ADD, OP_AND, OP_LT, OP_MUL, OP_SUB: begin
        need  = 2'd2;
        gives = 2'd1;
      end
      OP_CONST, OP_LOAD: begin
        gives = 2'd1;
      end
      OP_IFFALSE, OP_STORE, OP_PRINT: begin
        need = 2'd1;
      end
      OP_NOT: begin
        need  = 2'd1;
        gives = 2'd1;
      end
      default: begin
      end
    endcase
  end

  // Binary operation result: a is the entry below the top, b the top.
  always_comb begin
    case (op_q)
      OP_ADD:  bin_r = t1_q + t0_q;
      OP_SUB:  bin_r = t1_q - t0_q;
      OP_MUL:  bin_r = mul_r;
      OP_AND:  bin_r = WORD_W'((t1_q != '0) && (t0_q != '0));
      OP_LT:   bin_r = WORD_W'($signed(t1_q) < $signed(t0_q));
      default: bin_r = '0;
    endcase
  end

  assign push_v = (op_q == OP_LOAD) ? (lin_q ? lrd_q : '0) : arg_q;

  // Execute one instruction; hold all state when nothing executes.
  always_comb begin
    top_d     = top_q;
    t0_d      = t0_q;
    t1_d      = t1_q;
    level_d   = level_q;
    method_d  = method_q;
    pc_d      = pc_q;
    stopped_d = stopped_q;
    fault     = FAULT_NONE;
    pv        = 1'b0;
    pval      = '0;
    swe       = 1'b0;
    swaddr    = '0;
    swdata    = bin_r;
    fwe       = 1'b0;
    fwaddr    = level_q;
    fwdata    = {method_q, pc_next};
    lwe       = 1'b0;
    lwaddr    = BW'(level_q) * BW'(LOCALS_PER_FRAME) + BW'(arg_q[LW-1:0]);
    lwdata    = t0_q;

    // Apply a staged entry method write only before the first instruction.
    if (cfg_pend_q && fresh_q) begin
      method_d = cfg_rem;
    end

    if (exec_fire && !stopped_q) begin
      pc_d = pc_next;
      if (top_q < TW'(need)) begin
        fault = FAULT_UNDERFLOW;
      end else if ((32'(top_q) - 32'(need) + 32'(gives)) > 32'(STACK_DEPTH)) begin
        fault = FAULT_OVERFLOW;
      end else begin
        case (op_q)
          OP_GOTO: begin
            pc_d = jump_pc;
          end
          OP_CONST, OP_LOAD: begin
            swe    = 1'b1;
            swaddr = top_q[AW-1:0];
            swdata = push_v;
            t0_d   = push_v;
            t1_d   = t0_q;
            top_d  = top_q + TW'(1);
          end
          OP_ADD, OP_AND, OP_LT, OP_MUL, OP_SUB: begin
            swe    = 1'b1;
            swaddr = AW'(top_q - TW'(2));
            swdata = bin_r;
            t0_d   = bin_r;
            t1_d   = srd_q;
            top_d  = top_q - TW'(1);
          end
          OP_NOT: begin
            swe    = 1'b1;
            swaddr = AW'(top_q - TW'(1));
            swdata = WORD_W'(t0_q == '0);
            t0_d   = WORD_W'(t0_q == '0);
          end
          OP_IFFALSE, OP_STORE, OP_PRINT: begin
            t0_d  = t1_q;
            t1_d  = srd_q;
            top_d = top_q - TW'(1);
            if (op_q == OP_IFFALSE && t0_q == '0) begin
              pc_d = jump_pc;
            end
            if (op_q == OP_STORE) begin
              lwe = arg_in_range;
            end
            if (op_q == OP_PRINT) begin
              pv   = 1'b1;
              pval = t0_q;
            end
          end
          OP_CALL: begin
            if (level_q == FW'(CALL_DEPTH - 1)) begin
              fault = FAULT_CALL;
            end else begin
              fwe      = 1'b1;
              level_d  = level_q + FW'(1);
              method_d = call_m;
              pc_d     = '0;
            end
          end
          OP_RET: begin
            if (level_q == '0) begin
              fault = FAULT_CALL;
            end else begin
              level_d  = level_q - FW'(1);
              method_d = frd_q[MW+PW-1:PW];
              pc_d     = frd_q[PW-1:0];
            end
          end
          OP_STOP: begin
            stopped_d = 1'b1;
            pc_d      = pc_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Prefetch addresses follow the state that the next instruction will see.
  assign top_m3 = top_d - TW'(3);
  assign sraddr = (top_d >= TW'(3)) ? top_m3[AW-1:0] : '0;
  assign fraddr = level_d - FW'(1);
  assign lraddr = BW'(level_d) * BW'(LOCALS_PER_FRAME) + BW'(s_axis_tdata[LW-1:0]);

  // Stack memory: write-through of every entry, third entry read ahead.
  always_ff @(posedge clk_i) begin
    if (swe) begin
      stack_mem[swaddr] <= swdata;
    end
    if (exec_fire) begin
      srd_q <= (swe && swaddr == sraddr) ? swdata : stack_mem[sraddr];
    end
  end

  // Frame memory: return frame of the current level read ahead.
  always_ff @(posedge clk_i) begin
    if (fwe) begin
      frame_mem[fwaddr] <= fwdata;
    end
    if (exec_fire) begin
      frd_q <= (fwe && fwaddr == fraddr) ? fwdata : frame_mem[fraddr];
    end
  end

  // Local bank: read on capture so that a load finds its value in the input register.
  always_ff @(posedge clk_i) begin
    if (lwe) begin
      local_mem[lwaddr] <= lwdata;
    end
    if (s_fire) begin
      lrd_q <= (lwe && lwaddr == lraddr) ? lwdata : local_mem[lraddr];
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q  <= op_e'(s_axis_tuser);
      arg_q <= s_axis_tdata;
      pcq_q <= pc_quot;
      mq_q  <= m_quot;
      lin_q <= s_axis_tdata < 32'(LOCALS_PER_FRAME);
    end
    if (cfg_we_i) begin
      cfg_x_q    <= 32'(cfg_wdata_i);
      cfg_quot_q <= cfg_quot;
    end
  end

  // Cached top of stack.
  always_ff @(posedge clk_i) begin
    t0_q <= t0_d;
    t1_q <= t1_d;
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      o_method_q <= method_d;
      o_pc_q     <= pc_d;
      o_pv_q     <= pv;
      o_pval_q   <= pval;
      o_halt_q   <= stopped_d;
      o_fault_q  <= fault;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q       <= 1'b0;
      ov_q       <= 1'b0;
      top_q      <= '0;
      level_q    <= '0;
      method_q   <= '0;
      pc_q       <= '0;
      stopped_q  <= 1'b0;
      fresh_q    <= 1'b1;
      cfg_pend_q <= 1'b0;
    end else begin
      if (s_fire) begin
        iv_q <= 1'b1;
      end else if (exec_fire) begin
        iv_q <= 1'b0;
      end
      if (exec_fire) begin
        ov_q    <= 1'b1;
        fresh_q <= 1'b0;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      top_q      <= top_d;
      level_q    <= level_d;
      method_q   <= method_d;
      pc_q       <= pc_d;
      stopped_q  <= stopped_d;
      cfg_pend_q <= cfg_we_i;
    end
  end

  // Pack the result transaction.
  assign o_method_ext  = 32'(o_method_q);
  assign o_pc_ext      = 32'(o_pc_q);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, o_fault_q, o_halt_q, o_pval_q,
                          o_pc_ext[9:0], o_method_ext[7:0]};
  assign m_axis_tuser  = o_pv_q;

endmodule

>>> verif/stack_bytecode_executor_unit_tb.sv
// Self-checking testbench for the stack bytecode executor: directed program, random programs, halt.
module stack_bytecode_executor_unit_tb;
  import sbe_pkg::*;

  localparam int VALUE_DEPTH      = 64;
  localparam int FRAME_DEPTH      = 16;
  localparam int LOCALS_PER_FRAME = 16;
  localparam int METHOD_COUNT     = 256;
  localparam int METHOD_LENGTH    = 1024;

  localparam int RANDOM_ITEMS    = 1215;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PRESSURE_AT     = 300;  // result count at which the sink holds off
  localparam int PRESSURE_CYCLES = 400;
  localparam logic [7:0] START_METHOD = 8'hA5;

  typedef struct packed {
    logic [7:0]  fetch_method;
    logic [9:0]  fetch_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        halted;
    fault_e      fault;
  } fetch_result_t;

  typedef struct packed {
    op_e           op;
    logic [31:0]   arg;
    logic          typed;  // 1: check against want instead of the predictor
    fetch_result_t want;
  } program_row_t;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} gen_mode_e;

  localparam op_e BINARY_OPS [5] = '{OP_ADD, OP_AND, OP_LT, OP_MUL, OP_SUB};

  // Opening program: error paths on an empty machine, wrap-around arithmetic, signed
  // compare at the extremes, target wrap for jumps and calls, locals in and out of range.
  localparam program_row_t OPENING [27] = '{
    '{OP_ADD,     32'h0000_0000, 1'b1, '{START_METHOD, 10'd1, 1'b0, 32'd0, 1'b0, FAULT_UNDERFLOW}},
    '{OP_RET,     32'h0000_0000, 1'b1, '{START_METHOD, 10'd2, 1'b0, 32'd0, 1'b0, FAULT_CALL}},
    '{OP_PRINT,   32'h0000_0000, 1'b1, '{START_METHOD, 10'd3, 1'b0, 32'd0, 1'b0, FAULT_UNDERFLOW}},
    '{OP_CONST,   32'h7FFF_FFFF, 1'b1, '{START_METHOD, 10'd4, 1'b0, 32'd0, 1'b0, FAULT_NONE}},
    '{OP_CONST,   32'h0000_0001, 1'b0, '0},
    '{OP_ADD,     32'h0000_0000, 1'b0, '0},
    '{OP_PRINT,   32'h0000_0000, 1'b1,
      '{START_METHOD, 10'd7, 1'b1, 32'h8000_0000, 1'b0, FAULT_NONE}},
    '{OP_CONST,   32'h8000_0000, 1'b0, '0},
    '{OP_CONST,   32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LT,      32'h0000_0000, 1'b0, '0},
    '{OP_CONST,   32'h0001_0000, 1'b0, '0},
    '{OP_CONST,   32'h0001_0000, 1'b0, '0},
    '{OP_MUL,     32'h0000_0000, 1'b0, '0},
    '{OP_AND,     32'h0000_0000, 1'b0, '0},
    '{OP_IFFALSE, 32'hFFFF_FFFF, 1'b1, '{START_METHOD, 10'd1023, 1'b0, 32'd0, 1'b0, FAULT_NONE}},
    '{OP_NOP,     32'h0000_0000, 1'b1, '{START_METHOD, 10'd0, 1'b0, 32'd0, 1'b0, FAULT_NONE}},
    '{OP_STORE,   32'h0000_0003, 1'b1, '{START_METHOD, 10'd1, 1'b0, 32'd0, 1'b0, FAULT_UNDERFLOW}},
    '{OP_CONST,   32'h0000_002A, 1'b0, '0},
    '{OP_STORE,   32'h0000_000F, 1'b0, '0},
    '{OP_LOAD,    32'h0000_000F, 1'b0, '0},
    '{OP_LOAD,    32'h8000_0000, 1'b0, '0},
    '{OP_SUB,     32'h0000_0000, 1'b0, '0},
    '{OP_CALL,    32'h0000_01FF, 1'b1, '{8'hFF, 10'd0, 1'b0, 32'd0, 1'b0, FAULT_NONE}},
    '{OP_GOTO,    32'hFFFF_FFFF, 1'b1, '{8'hFF, 10'd1023, 1'b0, 32'd0, 1'b0, FAULT_NONE}},
    '{OP_RET,     32'h0000_0000, 1'b1, '{START_METHOD, 10'd7, 1'b0, 32'd0, 1'b0, FAULT_NONE}},
    '{OP_NOT,     32'h0000_0000, 1'b0, '0},
    '{OP_PRINT,   32'h0000_0000, 1'b1, '{START_METHOD, 10'd9, 1'b1, 32'd0, 1'b0, FAULT_NONE}}
  };

  // Closing program: stop, then instructions that the halted machine must ignore.
  localparam program_row_t HALTING [5] = '{
    '{OP_STOP,  32'h0000_0000, 1'b0, '0},
    '{OP_CONST, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_CALL,  32'h0000_0011, 1'b0, '0},
    '{OP_PRINT, 32'h0000_0000, 1'b0, '0},
    '{OP_GOTO,  32'h0000_0155, 1'b0, '0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = 32'd0;  // [31:0] operand
  logic [3:0]  s_axis_tuser  = 4'd0;   // [3:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;           // [7:0] fetch_method, [17:8] fetch_pc,
                                       // [49:18] print_value, [50] halted, [52:51] fault
  logic [0:0]  m_axis_tuser;           // [0] print_valid

  stack_bytecode_executor_unit #(
    .STACK_DEPTH     (VALUE_DEPTH),
    .CALL_DEPTH      (FRAME_DEPTH),
    .LOCALS_PER_FRAME(LOCALS_PER_FRAME),
    .METHOD_COUNT    (METHOD_COUNT),
    .METHOD_LENGTH   (METHOD_LENGTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Machine state as it stands after every accepted instruction.
  logic [31:0] value_mem [VALUE_DEPTH];
  int          value_depth = 0;
  logic [7:0]  ret_method [FRAME_DEPTH];
  logic [9:0]  ret_pc [FRAME_DEPTH];
  int          frame_level = 0;
  logic [31:0] local_mem [FRAME_DEPTH * LOCALS_PER_FRAME];
  bit          local_set [FRAME_DEPTH * LOCALS_PER_FRAME];
  logic [7:0]  entry_reg  = 8'd0;
  logic [7:0]  cur_method = 8'd0;
  logic [9:0]  cur_pc     = 10'd0;
  bit          stopped    = 1'b0;
  bit          fresh      = 1'b1;  // no instruction executed since reset

  fetch_result_t pending_fetches [$];
  int            mismatches = 0;
  gen_mode_e     gen_mode   = MODE_MIX;
  int            send_left = 0, recv_left = 0;
  bit            send_quiet = 1'b0, recv_quiet = 1'b0;
  int            cycle_count = 0;

  function automatic void push_value(logic [31:0] v);
    value_mem[value_depth] = v;
    value_depth++;
  endfunction

  function automatic logic [31:0] pop_value();
    value_depth--;
    return value_mem[value_depth];
  endfunction

  // Execute one instruction on the machine state and return the fetch result it produces.
  function automatic fetch_result_t execute_bytecode(op_e op, logic [31:0] arg);
    logic [9:0]  pc_next;
    int          need, gives, slot;
    fault_e      flt;
    logic [31:0] a, b, pval;
    logic        pv;
    pc_next = cur_pc + 10'd1;  // wraps at the method length
    need    = 0;
    gives   = 0;
    flt     = FAULT_NONE;
    pv      = 1'b0;
    pval    = 32'd0;
    fresh   = 1'b0;
    if (!stopped) begin
      case (op)
        OP_ADD, OP_AND, OP_LT, OP_MUL, OP_SUB: begin
          need  = 2;
          gives = 1;
        end
        OP_CONST, OP_LOAD: gives = 1;
        OP_IFFALSE, OP_STORE, OP_PRINT: need = 1;
        OP_NOT: begin
          need  = 1;
          gives = 1;
        end
        default: ;
      endcase
      if (value_depth < need) flt = FAULT_UNDERFLOW;
      else if (value_depth - need + gives > VALUE_DEPTH) flt = FAULT_OVERFLOW;

      if (flt == FAULT_NONE) begin
        case (op)
          OP_GOTO: pc_next = arg[9:0];
          OP_ADD: begin
            b = pop_value();
            a = pop_value();
            push_value(a + b);
          end
          OP_AND: begin
            b = pop_value();
            a = pop_value();
            push_value({31'd0, (a != 32'd0) && (b != 32'd0)});
          end
          OP_CONST: push_value(arg);
          OP_IFFALSE: if (pop_value() == 32'd0) pc_next = arg[9:0];
          OP_LOAD: begin
            slot = frame_level * LOCALS_PER_FRAME + int'(arg[3:0]);
            if (arg < LOCALS_PER_FRAME && local_set[slot]) push_value(local_mem[slot]);
            else push_value(32'd0);
          end
          OP_LT: begin
            b = pop_value();
            a = pop_value();
            push_value({31'd0, $signed(a) < $signed(b)});
          end
          OP_MUL: begin
            b = pop_value();
            a = pop_value();
            push_value(a * b);
          end
          OP_NOT: push_value({31'd0, pop_value() == 32'd0});
          OP_CALL: begin
            if (frame_level + 1 >= FRAME_DEPTH) begin
              flt = FAULT_CALL;
            end else begin
              ret_method[frame_level] = cur_method;
              ret_pc[frame_level]     = pc_next;
              frame_level++;
              // the callee starts with a blank set of locals
              for (int k = 0; k < LOCALS_PER_FRAME; k++)
                local_set[frame_level * LOCALS_PER_FRAME + k] = 1'b0;
              cur_method = arg[7:0];
              pc_next    = 10'd0;
            end
          end
          OP_RET: begin
            if (frame_level == 0) begin
              flt = FAULT_CALL;
            end else begin
              frame_level--;
              cur_method = ret_method[frame_level];
              pc_next    = ret_pc[frame_level];
            end
          end
          OP_STORE: begin
            a = pop_value();
            if (arg < LOCALS_PER_FRAME) begin
              slot = frame_level * LOCALS_PER_FRAME + int'(arg[3:0]);
              local_mem[slot] = a;
              local_set[slot] = 1'b1;
            end
          end
          OP_SUB: begin
            b = pop_value();
            a = pop_value();
            push_value(a - b);
          end
          OP_PRINT: begin
            pv   = 1'b1;
            pval = pop_value();
          end
          OP_STOP: begin
            stopped = 1'b1;
            pc_next = cur_pc;
          end
          default: ;
        endcase
      end
      cur_pc = pc_next;
    end
    return '{cur_method, cur_pc, pv, pval, stopped, flt};
  endfunction

  // Gap length for one side: mostly short, a few long, with quiet stretches of no gaps.
  function automatic int pick_gap(inout int left, inout bit quiet);
    int r;
    if (left == 0) begin
      quiet = ($urandom_range(0, 3) == 0);
      left  = $urandom_range(20, 80);
    end
    left--;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Write the entry method; before the first instruction it also moves the start method.
  task automatic write_entry(logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    entry_reg = v;
    if (fresh) cur_method = v;
  endtask

  // Drop valid and wait until every pending result has drained.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_fetches.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one instruction, hold it until accepted, then queue its expected result.
  task automatic offer_instr(op_e op, logic [31:0] arg, logic typed, fetch_result_t want);
    int            gap;
    fetch_result_t predicted;
    gap = pick_gap(send_left, send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= arg;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predicted = execute_bytecode(op, arg);
    pending_fetches.push_back(typed ? want : predicted);
  endtask

  // Pick a random instruction shaped by the current mode; never load an unwritten local.
  task automatic pick_random_instr(output op_e op, output logic [31:0] arg);
    int r;
    int valid_idx [$];
    arg = $urandom;
    r   = $urandom_range(0, 99);
    if (r < 5) begin
      // noise: any opcode except the ones that end the run or need a written local
      op = op_e'($urandom_range(0, 15));
      if (op == OP_STOP || op == OP_LOAD) op = OP_NOP;
    end else begin
      r = $urandom_range(0, 99);
      case (gen_mode)
        MODE_FILL: begin
          if (r < 50) op = OP_CONST;
          else if (r < 65) op = OP_LOAD;
          else if (r < 80) op = OP_CALL;
          else if (r < 88) op = BINARY_OPS[$urandom_range(0, 4)];
          else if (r < 92) op = OP_STORE;
          else if (r < 96) op = OP_GOTO;
          else op = OP_NOT;
        end
        MODE_DRAIN: begin
          if (r < 35) op = BINARY_OPS[$urandom_range(0, 4)];
          else if (r < 50) op = OP_PRINT;
          else if (r < 60) op = OP_STORE;
          else if (r < 75) op = OP_RET;
          else if (r < 85) op = OP_IFFALSE;
          else if (r < 90) op = OP_NOT;
          else op = OP_CONST;
        end
        default: begin
          op = op_e'($urandom_range(0, 15));
          if (op == OP_STOP) op = OP_NOP;
          if (value_depth < 2 && r < 40) op = OP_CONST;
        end
      endcase
    end

    case (op)
      OP_CONST: begin
        case ($urandom_range(0, 9))
          0: arg = 32'h8000_0000;
          1: arg = 32'h7FFF_FFFF;
          2: arg = 32'h0000_0000;
          3: arg = 32'hFFFF_FFFF;
          4, 5: arg = $urandom_range(0, 9);
          default: ;
        endcase
      end
      OP_STORE: if ($urandom_range(0, 4) != 0) arg = $urandom_range(0, LOCALS_PER_FRAME - 1);
      OP_LOAD: begin
        for (int k = 0; k < LOCALS_PER_FRAME; k++)
          if (local_set[frame_level * LOCALS_PER_FRAME + k]) valid_idx.push_back(k);
        if (valid_idx.size() != 0 && $urandom_range(0, 6) != 0)
          arg = valid_idx[$urandom_range(0, valid_idx.size() - 1)];
        else if (arg < LOCALS_PER_FRAME)
          arg = arg + LOCALS_PER_FRAME;  // push the index out of range
      end
      default: ;
    endcase
  endtask

  // Result side: random stalls, one long hold-off so the block backs up, then check
  // each result against the oldest pending expectation.
  initial begin : result_sink
    fetch_result_t got, want;
    int            stall;
    int            received;
    bit            held;
    received = 0;
    held     = 1'b0;
    forever begin
      stall = pick_gap(recv_left, recv_quiet);
      if (!held && received == PRESSURE_AT) begin
        held  = 1'b1;
        stall = PRESSURE_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      received++;
      got = '{m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tuser[0], m_axis_tdata[49:18],
              m_axis_tdata[50], fault_e'(m_axis_tdata[52:51])};
      if (pending_fetches.size() == 0) begin
        $error("result with nothing pending: fetch_method %0d fetch_pc %0d",
               got.fetch_method, got.fetch_pc);
        mismatches++;
      end else begin
        want = pending_fetches.pop_front();
        if (got.fetch_method !== want.fetch_method) begin
          $error("fetch_method: expected %0d, got %0d", want.fetch_method, got.fetch_method);
          mismatches++;
        end
        if (got.fetch_pc !== want.fetch_pc) begin
          $error("fetch_pc: expected %0d, got %0d", want.fetch_pc, got.fetch_pc);
          mismatches++;
        end
        if (got.print_valid !== want.print_valid) begin
          $error("print_valid: expected %0b, got %0b", want.print_valid, got.print_valid);
          mismatches++;
        end
        if (got.print_value !== want.print_value) begin
          $error("print_value: expected %h, got %h", want.print_value, got.print_value);
          mismatches++;
        end
        if (got.halted !== want.halted) begin
          $error("halted: expected %0b, got %0b", want.halted, got.halted);
          mismatches++;
        end
        if (got.fault !== want.fault) begin
          $error("fault: expected %0d, got %0d", want.fault, got.fault);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run with a failure once the cycle limit is reached.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    op_e         op;
    logic [31:0] arg;
    int          mode_left;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Entry method before the first instruction: both extremes, then the start method.
    write_entry(8'hFF);
    write_entry(8'h00);
    write_entry(START_METHOD);

    foreach (OPENING[i]) offer_instr(OPENING[i].op, OPENING[i].arg, OPENING[i].typed, OPENING[i].want);

    settle();
    write_entry(8'($urandom_range(0, 255)));

    // Cycle through mixed, filling and draining stretches so the stacks hit both limits.
    mode_left = $urandom_range(80, 250);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        settle();
        write_entry(8'h00);
      end
      if (mode_left == 0) begin
        gen_mode  = gen_mode_e'((int'(gen_mode) + 1) % 3);
        mode_left = $urandom_range(80, 250);
      end
      mode_left--;
      pick_random_instr(op, arg);
      offer_instr(op, arg, 1'b0, '0);
    end

    settle();
    write_entry(8'hFF);
    foreach (HALTING[i]) offer_instr(HALTING[i].op, HALTING[i].arg, HALTING[i].typed, HALTING[i].want);
    s_axis_tvalid <= 1'b0;

    while (pending_fetches.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
hdl/sbe_pkg.sv
hdl/sbe_modc.sv
hdl/stack_bytecode_executor_unit.sv
verif/stack_bytecode_executor_unit_tb.sv
